// ===== sv/isp_fcg_pkg.sv =====
`default_nettype none

package isp_fcg_pkg;

	localparam int PAGE_BYTES     = 128;
	localparam int FLASH_BYTES    = 16384;
	localparam int WORDS_PER_PAGE = PAGE_BYTES / 2;

	localparam int POS_W    = 15;
	localparam int LIMIT_W  = 15;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int WADDR_W  = 16;
	localparam int MAX_CMDS = 4;
	localparam int CNT_W    = $clog2(MAX_CMDS + 1);
	localparam int IDX_W    = $clog2(MAX_CMDS);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16384);

	// register index taken from paddr above the byte offset
	localparam logic REG_IMAGE_LIMIT = 1'b0;

	localparam logic [7:0] OP_PGM     = 8'hac;
	localparam logic [7:0] SUB_ENABLE = 8'h53;
	localparam logic [7:0] SUB_ERASE  = 8'h80;
	localparam logic [7:0] OP_LOAD_LO = 8'h40;
	localparam logic [7:0] OP_LOAD_HI = 8'h48;
	localparam logic [7:0] OP_PAGE_WR = 8'h4c;

	typedef struct packed {
		logic [7:0] op_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
		logic [7:0] fourth_byte;
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic run_end;
	} word_t;

endpackage

`default_nettype wire

// ===== sv/isp_fcg_regs.sv =====
`default_nettype none

module isp_fcg_regs (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [isp_fcg_pkg::ADDR_W-1:0]    paddr,
	input  wire  [isp_fcg_pkg::DATA_W-1:0]    pwdata,
	output logic [isp_fcg_pkg::DATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [isp_fcg_pkg::LIMIT_W-1:0]   image_limit
);
	import isp_fcg_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en && paddr[ADDR_W-1] == REG_IMAGE_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1] == REG_IMAGE_LIMIT) begin
			prdata = DATA_W'(limit_q);
		end
	end

	assign image_limit = limit_q;

endmodule

`default_nettype wire

// ===== sv/isp_fcg_plan.sv =====
`default_nettype none

module isp_fcg_plan (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [isp_fcg_pkg::LIMIT_W-1:0]   image_limit,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [7:0]                        data_byte,
	input  wire                               last_byte,
	output logic                              word_valid,
	input  wire                               word_ready,
	output isp_fcg_pkg::word_t                word
);
	import isp_fcg_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] eff;
	logic [POS_W-1:0] final_pos;
	logic [WADDR_W-1:0] word_in_page;
	logic             below;
	logic             boundary;
	logic             accept;
	logic             take;

	cmd_t             list [MAX_CMDS];
	logic [CNT_W-1:0] n;

	cmd_t             slots_s1 [MAX_CMDS];
	logic [CNT_W-1:0] rem_s1;
	logic [IDX_W-1:0] rd_s1;

	function automatic cmd_t page_write(input logic [POS_W-1:0] page);
		logic [WADDR_W-1:0] waddr;
		cmd_t c;
		waddr = WADDR_W'(page) * WADDR_W'(WORDS_PER_PAGE);
		c.op_byte     = OP_PAGE_WR;
		c.second_byte = waddr[15:8];
		c.third_byte  = waddr[7:0];
		c.fourth_byte = 8'h00;
		return c;
	endfunction

	always_comb begin
		eff = image_limit;
		if (image_limit == '0) begin
			eff = POS_W'(1);
		end else if (image_limit > POS_W'(FLASH_BYTES)) begin
			eff = POS_W'(FLASH_BYTES);
		end
	end

	assign below        = pos_q < eff;
	assign final_pos    = below ? pos_q : eff - POS_W'(1);
	assign boundary     = (pos_q != '0) && (pos_q % POS_W'(PAGE_BYTES) == '0);
	assign word_in_page = WADDR_W'((pos_q >> 1) % POS_W'(WORDS_PER_PAGE));

	// build the instruction list this byte causes, in emission order
	always_comb begin
		for (int i = 0; i < MAX_CMDS; i++) begin
			list[i] = '0;
		end
		n = '0;
		if (pos_q == '0) begin
			list[n[IDX_W-1:0]] = '{OP_PGM, SUB_ENABLE, 8'h00, 8'h00};
			n = n + CNT_W'(1);
			list[n[IDX_W-1:0]] = '{OP_PGM, SUB_ERASE, 8'h00, 8'h00};
			n = n + CNT_W'(1);
		end
		if (below) begin
			if (boundary) begin
				list[n[IDX_W-1:0]] = page_write(pos_q / POS_W'(PAGE_BYTES) - POS_W'(1));
				n = n + CNT_W'(1);
			end
			list[n[IDX_W-1:0]] = '{(pos_q[0] ? OP_LOAD_HI : OP_LOAD_LO),
				word_in_page[15:8], word_in_page[7:0], data_byte};
			n = n + CNT_W'(1);
		end
		if (last_byte) begin
			list[n[IDX_W-1:0]] = page_write(final_pos / POS_W'(PAGE_BYTES));
			n = n + CNT_W'(1);
		end
	end

	always_comb begin
		pos_next = below ? pos_q + POS_W'(1) : eff;
		if (last_byte) begin
			pos_next = '0;
		end
	end

	assign word_valid   = rem_s1 != '0;
	assign take         = word_valid && word_ready;
	assign word.cmd     = slots_s1[rd_s1];
	assign word.run_end = rem_s1 == CNT_W'(1);
	assign in_ready     = (rem_s1 == '0) || (rem_s1 == CNT_W'(1) && take);
	assign accept       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			rem_s1 <= '0;
			rd_s1  <= '0;
		end else if (accept) begin
			pos_q  <= pos_next;
			rem_s1 <= n;
			rd_s1  <= '0;
		end else if (take) begin
			rem_s1 <= rem_s1 - CNT_W'(1);
			rd_s1  <= rd_s1 + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_CMDS; i++) begin
				slots_s1[i] <= list[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_s1 <= CNT_W'(MAX_CMDS))
		else $error("instruction buffer count out of range");

	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (rem_s1 == '0 || (rem_s1 == CNT_W'(1) && take)))
		else $error("byte taken while earlier instructions remain");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> pos_q == '0)
		else $error("byte position not cleared after last byte");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(FLASH_BYTES))
		else $error("byte position beyond flash size");
`endif

endmodule

`default_nettype wire

// ===== sv/isp_fcg_out.sv =====
`default_nettype none

module isp_fcg_out (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  word_valid,
	output logic                 word_ready,
	input  isp_fcg_pkg::word_t   word,
	output logic                 out_valid,
	input  wire                  out_ready,
	output isp_fcg_pkg::word_t   out_word
);
	import isp_fcg_pkg::*;

	logic  valid_q;
	word_t word_q;

	assign word_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (word_ready) begin
			valid_q <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_ready && word_valid) begin
			word_q <= word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

`default_nettype wire

// ===== sv/isp_flash_command_generator.sv =====
// channel   direction   handshake              word
// cfg       in/out      psel/penable/pready    paddr, pwdata, prdata (image_limit)
// in        in          in_valid/in_ready      data_byte, last_byte
// out       out         out_valid/out_ready    op_byte .. fourth_byte, run_end
//
// each image byte yields zero to four instructions, sent one per cycle
// through the single output register while out is not stalled
// a new byte is taken in the cycle its predecessor's last instruction moves on
// reset: byte position 0, image_limit 16384, no instruction pending
// a stall on out holds the output word and, once the buffer drains, in_ready
`default_nettype none

module isp_flash_command_generator (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [isp_fcg_pkg::ADDR_W-1:0]   paddr,
	input  wire  [isp_fcg_pkg::DATA_W-1:0]   pwdata,
	output logic [isp_fcg_pkg::DATA_W-1:0]   prdata,
	output logic                             pready,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [7:0]                       data_byte,
	input  wire                              last_byte,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [7:0]                       op_byte,
	output logic [7:0]                       second_byte,
	output logic [7:0]                       third_byte,
	output logic [7:0]                       fourth_byte,
	output logic                             run_end
);
	import isp_fcg_pkg::*;

	logic [LIMIT_W-1:0] image_limit;
	logic               word_valid;
	logic               word_ready;
	word_t              word;
	word_t              out_word;

	isp_fcg_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.image_limit (image_limit)
	);

	isp_fcg_plan u_plan (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_limit (image_limit),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.word        (word)
	);

	isp_fcg_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word)
	);

	assign op_byte     = out_word.cmd.op_byte;
	assign second_byte = out_word.cmd.second_byte;
	assign third_byte  = out_word.cmd.third_byte;
	assign fourth_byte = out_word.cmd.fourth_byte;
	assign run_end     = out_word.run_end;

endmodule

`default_nettype wire
